@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, switched off while rst_n is low.
`define NDCQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define NDCQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ndcq_pkg.sv @@
// ----------------------------------------------------------------------------
// ndcq_pkg
// Types and constants for the nearest droplet coverage query block.
// ----------------------------------------------------------------------------
package ndcq_pkg;

    // Operation codes carried in the request beat
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Field widths
    localparam int unsigned COORD_W = 16;
    localparam int unsigned PIXEL_W = 12;
    localparam int unsigned FRAC_W  = 4;
    localparam int unsigned SQ_W    = 2 * COORD_W;
    localparam int unsigned DIST_W  = SQ_W + 1;

    // Request beat
    typedef struct packed {
        logic [1:0]                operation;
        logic [COORD_W-1:0]        center_x;
        logic [COORD_W-1:0]        center_y;
        logic [COORD_W-1:0]        radius;
        logic signed [COORD_W-1:0] contact_angle;
        logic [COORD_W-1:0]        droplet_id;
        logic [PIXEL_W-1:0]        pixel_x;
        logic [PIXEL_W-1:0]        pixel_y;
    } t_in_item;

    // Response beat
    typedef struct packed {
        logic                      covered;
        logic                      found;
        logic signed [COORD_W-1:0] nearest_angle;
        logic [COORD_W-1:0]        nearest_id;
        logic                      table_full;
    } t_out_item;

    // One stored droplet
    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        radius;
        logic signed [COORD_W-1:0] angle;
        logic [COORD_W-1:0]        id;
    } t_droplet;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_ctrl_state;

    // Controller to datapath commands
    typedef struct packed {
        logic tbl_clear;
        logic tbl_append;
        logic scan_start;
        logic scan_step;
        logic rsp_load;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic tbl_empty;
        logic scan_last;
        logic pipe_busy;
        logic rsp_free;
    } t_dp_status;

endpackage

@@ rtl/ndcq_stream_if.sv @@
// ----------------------------------------------------------------------------
// ndcq_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ndcq_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/ndcq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ndcq_ctrl
// Sequencer: takes request beats, runs the table scan for a query and
// hands the finished result to the response register.
// ----------------------------------------------------------------------------
module ndcq_ctrl
    import ndcq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_op,
    output logic       o_req_ready,
    output t_ctrl_cmd  o_cmd,
    input  t_dp_status i_status
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        req_fire;

    assign req_fire = i_req_valid && o_req_ready;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire && (i_req_op == OP_QUERY)) begin
                    n_state = i_status.tbl_empty ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.rsp_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (req_fire) begin
                    unique case (i_req_op)
                        OP_CLEAR:  o_cmd.tbl_clear  = 1'b1;
                        OP_APPEND: o_cmd.tbl_append = 1'b1;
                        OP_QUERY:  o_cmd.scan_start = 1'b1;
                        default:   o_cmd            = '0;
                    endcase
                end
            end
            ST_SCAN:  o_cmd.scan_step = 1'b1;
            ST_DRAIN: o_cmd           = '0;
            ST_DONE:  o_cmd.rsp_load  = i_status.rsp_free;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

@@ rtl/ndcq_dpath.sv @@
// ----------------------------------------------------------------------------
// ndcq_dpath
// Droplet table memory, distance pipeline, running nearest/coverage
// accumulator and the response register.
// ----------------------------------------------------------------------------
module ndcq_dpath
    import ndcq_pkg::*;
#(
    parameter int unsigned MAX_DROPLETS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    input  t_in_item   i_req_data,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    output t_out_item  o_rsp_data
);

    localparam int unsigned CNT_W = $clog2(MAX_DROPLETS + 1);
    localparam int unsigned IDX_W = (MAX_DROPLETS > 1) ? $clog2(MAX_DROPLETS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DROPLETS);

    // Table storage
    t_droplet           r_mem [MAX_DROPLETS];
    t_droplet           r_rdata;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_rd_idx;

    // Query pixel in Q12.4
    logic [PIXEL_W-1:0] r_px;
    logic [PIXEL_W-1:0] r_py;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;

    // Pipeline stages
    logic                      r_v1, r_v2, r_v3;
    logic [COORD_W-1:0]        r_dx, r_dy, r_rad;
    logic signed [COORD_W-1:0] r_ang2, r_ang3;
    logic [COORD_W-1:0]        r_id2, r_id3;
    logic [SQ_W-1:0]           r_dx2, r_dy2, r_r2;
    logic [COORD_W-1:0]        n_dx, n_dy;

    // Accumulator
    logic [DIST_W-1:0]         d2;
    logic                      in_disc;
    logic                      closer;
    logic [DIST_W-1:0]         r_best;
    logic                      r_have;
    logic                      r_cov;
    logic signed [COORD_W-1:0] r_best_ang;
    logic [COORD_W-1:0]        r_best_id;

    logic                      r_rsp_valid;
    t_out_item                 r_rsp_data;

    // Write the table on append, read one entry per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_append && (r_count < CNT_MAX)) begin
            r_mem[r_count[IDX_W-1:0]] <= '{x:      i_req_data.center_x,
                                           y:      i_req_data.center_y,
                                           radius: i_req_data.radius,
                                           angle:  i_req_data.contact_angle,
                                           id:     i_req_data.droplet_id};
        end
        if (i_cmd.scan_step) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    // Track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.tbl_clear) begin
            r_count <= '0;
        end else if (i_cmd.tbl_append && (r_count < CNT_MAX)) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Advance the scan address, capture the pixel at query start
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
            r_px     <= i_req_data.pixel_x;
            r_py     <= i_req_data.pixel_y;
        end else if (i_cmd.scan_step) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
    end

    assign pix_x = {r_px, {FRAC_W{1'b0}}};
    assign pix_y = {r_py, {FRAC_W{1'b0}}};

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Absolute coordinate differences
    always_comb begin
        n_dx = (r_rdata.x >= pix_x) ? (r_rdata.x - pix_x) : (pix_x - r_rdata.x);
        n_dy = (r_rdata.y >= pix_y) ? (r_rdata.y - pix_y) : (pix_y - r_rdata.y);
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_rad  <= r_rdata.radius;
        r_ang2 <= r_rdata.angle;
        r_id2  <= r_rdata.id;
    end

    // Squares
    always_ff @(posedge i_clk) begin
        r_dx2  <= r_dx * r_dx;
        r_dy2  <= r_dy * r_dy;
        r_r2   <= r_rad * r_rad;
        r_ang3 <= r_ang2;
        r_id3  <= r_id2;
    end

    // Squared distance, disc test and nearest test
    assign d2      = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign in_disc = (d2 <= {1'b0, r_r2});
    assign closer  = !r_have || (d2 < r_best);

    // Keep the first strictly nearest droplet and the coverage flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cov  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_have <= 1'b0;
            r_cov  <= 1'b0;
        end else if (r_v3) begin
            r_have <= 1'b1;
            r_cov  <= r_cov | in_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_best     <= '0;
            r_best_ang <= '0;
            r_best_id  <= '0;
        end else if (r_v3 && closer) begin
            r_best     <= d2;
            r_best_ang <= r_ang3;
            r_best_id  <= r_id3;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp_data <= '{covered:       r_cov,
                            found:         r_have,
                            nearest_angle: r_best_ang,
                            nearest_id:    r_best_id,
                            table_full:    (r_count >= CNT_MAX)};
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp_data  = r_rsp_data;

    // Status back to the sequencer
    assign o_status.tbl_empty = (r_count == '0);
    assign o_status.scan_last = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);
    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_status.rsp_free  = !r_rsp_valid || i_rsp_ready;

endmodule

@@ rtl/nearest_droplet_coverage_query_top.sv @@
// A query beat is answered once the table memory has yielded its N stored
// droplets, one per cycle on its single read port, the distance pipeline
// (absolute differences, then squares) has drained and the result is registered;
// an empty table skips the scan. A new request is taken only once the previous
// query has finished, but a response that is still waiting does not hold up
// clears, appends or the start of the next query.
// ----------------------------------------------------------------------------
// nearest_droplet_coverage_query_top
// Droplet table with nearest-droplet lookup and disc coverage test per pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_droplet_coverage_query_top
    import ndcq_pkg::*;
#(
    parameter int unsigned MAX_DROPLETS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ndcq_stream_if.sink   i_req,
    ndcq_stream_if.source o_rsp
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_in_item   req_data;
    t_out_item  rsp_data;
    logic       req_ready;
    logic       rsp_valid;

    assign req_data    = i_req.data;
    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp_data;

    // Sequencer
    ndcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (req_data.operation),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Table and distance datapath
    ndcq_dpath #(
        .MAX_DROPLETS (MAX_DROPLETS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_data  (req_data),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp_data  (rsp_data)
    );

    // Checks
    `NDCQ_ASSERT_ALWAYS(a_cmd_onehot, i_clk, $onehot0(cmd), "more than one datapath command")
    `NDCQ_ASSERT_RST(a_idle_pipe_empty, i_clk, i_rst_n, req_ready |-> !status.pipe_busy,
        "request taken while the scan pipeline still holds a droplet")
    `NDCQ_ASSERT_RST(a_load_shows, i_clk, i_rst_n, cmd.rsp_load |=> rsp_valid,
        "loaded response not presented")
    `NDCQ_ASSERT_RST(a_empty_result, i_clk, i_rst_n,
        (rsp_valid && !rsp_data.found) |->
        (!rsp_data.covered && (rsp_data.nearest_angle == '0) && (rsp_data.nearest_id == '0)),
        "empty-table response carries droplet data")

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest droplet coverage query block. Request
// beats (clear, append, query and the unused code) go in over a valid/ready
// channel; a scoreboard keeps its own droplet table, works out the lookup
// each accepted query should give and checks every response beat against
// the oldest outstanding lookup. Stimulus is a short directed set, a
// back-pressure episode, then random clear/append/query sequences across
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
    import ndcq_pkg::*;

    localparam int unsigned TABLE_DEPTH   = 256;
    localparam logic [1:0]  OP_RESERVED   = 2'd3;
    // Worst query wait: a scan of every droplet plus pipeline drain and result register
    localparam int unsigned QUERY_LATENCY = TABLE_DEPTH + 6;
    localparam int unsigned ITEM_TARGET   = 1250;
    // Roughly 1700 beats at worst wait plus the longest sender gap and
    // receiver stall each, hold-off and pauses, taken 4x
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;

    // Scoreboard: shadow droplet table and the lookups still owed by the block
    class droplet_table_checker;
        t_droplet    droplets [TABLE_DEPTH];
        int unsigned fill;
        t_out_item   expected_lookups [$];
        int unsigned mismatch_count;

        function new();
            fill           = 0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            mismatch_count++;
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        endtask

        // Walk the table as the block does; the earliest droplet wins a tie
        function t_out_item predict_lookup(input logic [PIXEL_W-1:0] pix_x,
                                           input logic [PIXEL_W-1:0] pix_y);
            longint unsigned px, py, cx, cy, dx, dy, dist2, best, rad;
            bit              have;
            t_out_item       res;
            px   = 64'({pix_x, {FRAC_W{1'b0}}});
            py   = 64'({pix_y, {FRAC_W{1'b0}}});
            res  = '0;
            have = 1'b0;
            best = 0;
            for (int unsigned i = 0; i < fill; i++) begin
                cx    = 64'(droplets[i].x);
                cy    = 64'(droplets[i].y);
                rad   = 64'(droplets[i].radius);
                dx    = (cx >= px) ? cx - px : px - cx;
                dy    = (cy >= py) ? cy - py : py - cy;
                dist2 = dx * dx + dy * dy;
                if (dist2 <= rad * rad) begin
                    res.covered = 1'b1;
                end
                if (!have || dist2 < best) begin
                    have              = 1'b1;
                    best              = dist2;
                    res.nearest_angle = droplets[i].angle;
                    res.nearest_id    = droplets[i].id;
                end
            end
            res.found      = have;
            res.table_full = (fill >= TABLE_DEPTH);
            return res;
        endfunction

        // Apply an accepted request beat to the shadow table
        function void note_request(input t_in_item beat);
            case (beat.operation)
                OP_CLEAR: begin
                    fill = 0;
                end
                OP_APPEND: begin
                    if (fill < TABLE_DEPTH) begin
                        droplets[fill].x      = beat.center_x;
                        droplets[fill].y      = beat.center_y;
                        droplets[fill].radius = beat.radius;
                        droplets[fill].angle  = beat.contact_angle;
                        droplets[fill].id     = beat.droplet_id;
                        fill++;
                    end
                end
                OP_QUERY: begin
                    expected_lookups.push_back(predict_lookup(beat.pixel_x, beat.pixel_y));
                end
                default: begin
                end
            endcase
        endfunction

        // Compare a response beat with the oldest outstanding lookup
        task check_response(input t_out_item got);
            t_out_item want;
            if (expected_lookups.size() == 0) begin
                report_mismatch("response with no query outstanding", 64'(got), '0);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.covered !== want.covered)
                report_mismatch("covered", 64'(got.covered), 64'(want.covered));
            if (got.found !== want.found)
                report_mismatch("found", 64'(got.found), 64'(want.found));
            if (got.nearest_angle !== want.nearest_angle)
                report_mismatch("nearest_angle", 64'(got.nearest_angle),
                                64'(want.nearest_angle));
            if (got.nearest_id !== want.nearest_id)
                report_mismatch("nearest_id", 64'(got.nearest_id), 64'(want.nearest_id));
            if (got.table_full !== want.table_full)
                report_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
        endtask

        function int unsigned pending();
            return expected_lookups.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ndcq_stream_if #(.t_payload(t_in_item))  req_if ();
    ndcq_stream_if #(.t_payload(t_out_item)) rsp_if ();

    nearest_droplet_coverage_query_top #(
        .MAX_DROPLETS(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    droplet_table_checker sb;
    int unsigned          sender_idle_pct;
    int unsigned          recv_stall_pct;
    int unsigned          hold_request;
    int unsigned          hold_left;
    int unsigned          items_counted;
    int unsigned          cycle_count;
    logic [15:0]          cluster_x;
    logic [15:0]          cluster_y;

    // Clock
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Response side: check each accepted beat, then pick ready for the next
    // cycle; a requested hold-off is counted down here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_response(rsp_if.data);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Beat with every field random, then the operation forced
    function automatic t_in_item noise_beat(input logic [1:0] op);
        t_in_item beat;
        beat.operation     = op;
        beat.center_x      = 16'($urandom);
        beat.center_y      = 16'($urandom);
        beat.radius        = 16'($urandom);
        beat.contact_angle = 16'($urandom);
        beat.droplet_id    = 16'($urandom);
        beat.pixel_x       = 12'($urandom);
        beat.pixel_y       = 12'($urandom);
        return beat;
    endfunction

    function automatic t_in_item append_beat(input logic [15:0] cx, input logic [15:0] cy,
                                             input logic [15:0] rad, input logic [15:0] ang,
                                             input logic [15:0] id);
        t_in_item beat;
        beat               = noise_beat(OP_APPEND);
        beat.center_x      = cx;
        beat.center_y      = cy;
        beat.radius        = rad;
        beat.contact_angle = ang;
        beat.droplet_id    = id;
        return beat;
    endfunction

    function automatic t_in_item query_beat(input logic [PIXEL_W-1:0] px,
                                            input logic [PIXEL_W-1:0] py);
        t_in_item beat;
        beat         = noise_beat(OP_QUERY);
        beat.pixel_x = px;
        beat.pixel_y = py;
        return beat;
    endfunction

    // Droplets mostly clustered, often on whole pixels so boundaries and
    // ties land exactly; now and then a copy of a stored centre
    function automatic t_in_item random_append();
        logic [15:0] cx, cy, rad;
        int unsigned k;
        if ($urandom_range(3) == 0) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
        end else if (sb.fill != 0 && $urandom_range(7) == 0) begin
            k  = $urandom_range(sb.fill - 1);
            cx = sb.droplets[k].x;
            cy = sb.droplets[k].y;
        end else begin
            cx = cluster_x + 16'($urandom_range(2047));
            cy = cluster_y + 16'($urandom_range(2047));
            if ($urandom_range(1) == 0) begin
                cx[FRAC_W-1:0] = '0;
                cy[FRAC_W-1:0] = '0;
            end
        end
        case ($urandom_range(3))
            0: rad = 16'($urandom);
            1: rad = 16'($urandom_range(15));
            default: rad = 16'($urandom_range(1023, 16));
        endcase
        if ($urandom_range(1) == 0) begin
            rad[FRAC_W-1:0] = '0;
        end
        return append_beat(cx, cy, rad, 16'($urandom), 16'($urandom));
    endfunction

    // Queries aimed around a stored droplet, some anywhere
    function automatic t_in_item random_query();
        t_droplet d;
        int       span, px, py;
        if (sb.fill == 0 || $urandom_range(4) == 0) begin
            return query_beat(12'($urandom), 12'($urandom));
        end
        d    = sb.droplets[$urandom_range(sb.fill - 1)];
        span = int'(d.radius >> FRAC_W) + 2;
        if (span > 64) begin
            span = 64;
        end
        px = int'(d.x >> FRAC_W) + int'($urandom_range(2 * span)) - span;
        py = int'(d.y >> FRAC_W) + int'($urandom_range(2 * span)) - span;
        if (px < 0) px = 0;
        if (px > 4095) px = 4095;
        if (py < 0) py = 0;
        if (py > 4095) py = 4095;
        return query_beat(px[PIXEL_W-1:0], py[PIXEL_W-1:0]);
    endfunction

    // Offer one request beat, idling first at the current rate; valid is
    // left high so back-to-back beats need no gap
    task automatic send_beat(input t_in_item beat);
        if (beat.operation != OP_RESERVED &&
            !(beat.operation == OP_APPEND && sb.fill >= TABLE_DEPTH)) begin
            items_counted++;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(beat);
    endtask

    // Drain every outstanding lookup, let the block settle, then switch rates
    task automatic enter_phase(input int unsigned ph);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUERY_LATENCY + 4) @(posedge i_clk);
        case (ph)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    initial begin
        int unsigned cur_phase, ph, full_fills, n_app, n_q;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.data     = '0;
        rsp_if.ready    = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        hold_left       = 0;
        items_counted   = 0;
        cycle_count     = 0;
        cluster_x       = '0;
        cluster_y       = '0;
        full_fills      = 0;
        sb              = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, unused code, boundary, extremes, clear, ties
        send_beat(query_beat(12'd0, 12'd0));
        send_beat(noise_beat(OP_RESERVED));
        send_beat(append_beat(16'd160, 16'd160, 16'd48, 16'h8000, 16'hFFFF));
        send_beat(query_beat(12'd13, 12'd10));
        send_beat(query_beat(12'd13, 12'd11));
        send_beat(append_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000));
        send_beat(append_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001));
        send_beat(query_beat(12'hFFF, 12'hFFF));
        send_beat(query_beat(12'd0, 12'd0));
        send_beat(query_beat(12'h800, 12'h7FF));
        send_beat(noise_beat(OP_CLEAR));
        send_beat(query_beat(12'd5, 12'd5));
        send_beat(append_beat(16'd320, 16'd320, 16'd32, 16'h0100, 16'd10));
        send_beat(append_beat(16'd384, 16'd320, 16'd32, 16'hFF00, 16'd11));
        send_beat(query_beat(12'd22, 12'd20));
        send_beat(append_beat(16'd320, 16'd320, 16'd0, 16'h0200, 16'd12));
        send_beat(query_beat(12'd20, 12'd20));
        send_beat(noise_beat(OP_RESERVED));
        send_beat(query_beat(12'd21, 12'd20));

        // Back-pressure: hold the response side off while queries keep coming
        cur_phase = 0;
        enter_phase(cur_phase);
        hold_request = 1500;
        send_beat(noise_beat(OP_CLEAR));
        repeat (6) send_beat(random_append());
        repeat (16) send_beat(random_query());

        // Random sequences, rotating through the idling phases
        while (items_counted < ITEM_TARGET) begin
            ph = (items_counted / 80) % 4;
            if (ph != cur_phase) begin
                enter_phase(ph);
                cur_phase = ph;
            end
            cluster_x = 16'($urandom);
            cluster_y = 16'($urandom);
            if (full_fills < 2 && items_counted >= 300 + full_fills * 450) begin
                // Fill the table, push past full, then query the full table
                send_beat(noise_beat(OP_CLEAR));
                while (sb.fill < TABLE_DEPTH) send_beat(random_append());
                repeat ($urandom_range(3, 1)) send_beat(random_append());
                repeat (6) send_beat(random_query());
                full_fills++;
            end else begin
                if ($urandom_range(9) < 7) begin
                    send_beat(noise_beat(OP_CLEAR));
                end
                n_app = $urandom_range(12, 1);
                n_q   = $urandom_range(8, 1);
                repeat (n_app) begin
                    if ($urandom_range(9) == 0)
                        send_beat(random_query());
                    else
                        send_beat(random_append());
                end
                repeat (n_q) begin
                    case ($urandom_range(19))
                        0: send_beat(noise_beat(OP_RESERVED));
                        1: send_beat(noise_beat(OP_CLEAR));
                        default: send_beat(random_query());
                    endcase
                end
            end
        end

        // Wind down: drain outstanding lookups and watch for stray beats
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUERY_LATENCY + 16) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
